[rtl/core/openvpn_flow_classifier_fsm_macros.svh]
// Assertion macros used by the checker module of the flow classifier.
`ifndef OPENVPN_FLOW_CLASSIFIER_FSM_MACROS_SVH
`define OPENVPN_FLOW_CLASSIFIER_FSM_MACROS_SVH

// The consequent must hold in the cycle after the antecedent.
`define OVFC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the same cycle as the antecedent.
`define OVFC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

[rtl/core/ovfc_pkg.sv]
package ovfc_pkg;

    localparam int CNT_W    = 32;
    localparam int NUM_W    = CNT_W + 7;
    localparam int RAT_W    = CNT_W + 3;
    localparam int IN_W     = 312;
    localparam int OUT_W    = 16;
    localparam int ADDR_W   = 3;

    typedef logic [CNT_W-1:0] t_count;
    typedef logic [3:0]       t_flow_state;

    localparam t_flow_state ST_IDLE         = 4'd0;
    localparam t_flow_state ST_RESET_CLIENT = 4'd1;
    localparam t_flow_state ST_RESET_SERVER = 4'd2;
    localparam t_flow_state ST_ACK          = 4'd3;
    localparam t_flow_state ST_CLIENT_HELLO = 4'd4;
    localparam t_flow_state ST_SERVER_HELLO = 4'd5;
    localparam t_flow_state ST_CONTROL_ACK  = 4'd6;
    localparam t_flow_state ST_DATA         = 4'd7;
    localparam t_flow_state ST_INVALID      = 4'd8;

    localparam logic [4:0] OP_HRC_V1  = 5'd1;
    localparam logic [4:0] OP_HRC_V2  = 5'd7;
    localparam logic [4:0] OP_HRC_V3  = 5'd10;
    localparam logic [4:0] OP_HRS_V1  = 5'd2;
    localparam logic [4:0] OP_HRS_V2  = 5'd8;
    localparam logic [4:0] OP_CONTROL = 5'd4;
    localparam logic [4:0] OP_ACK     = 5'd5;
    localparam logic [4:0] OP_DATA_V1 = 5'd6;
    localparam logic [4:0] OP_DATA_V2 = 5'd9;

    localparam logic       REG_MISS_THR = 1'b0;
    localparam logic       REG_MIN_LEN  = 1'b1;

    localparam logic [2:0] MISS_LIMIT   = 3'd4;
    localparam logic [2:0] MISS_MAX     = 3'd7;
    localparam logic [31:0] MIN_PKTS    = 32'd5;
    localparam logic [6:0] CONF_FULL    = 7'd100;
    localparam logic [6:0] CONF_MAX     = 7'd100;
    localparam logic [3:0] STATE_MAX    = 4'd8;

endpackage

[rtl/core/openvpn_flow_classifier_fsm.sv]
// OpenVPN flow classifier. Each word on the slave stream is one packet of a
// single flow; the block tracks the handshake state of that flow and returns
// one word on the master stream per packet, carrying the state and, where one
// applies, a confidence percentage. The two APB registers hold the miss
// threshold and the length that a large packet must exceed.
// An accepted packet updates the handshake state, the client address and the
// counters in the accept cycle. The confidence value then comes from a
// restoring divider that produces one quotient bit per cycle, seven in all,
// after a preparation step that forms the scaled numerator and the ratio test.
// The sequencer steps through the preparation, division and finish states,
// and skips the division when it is not needed. A packet is not taken before
// the sequencer has finished the previous one. s_axis_tready is high
// only while the sequencer is idle, and a new packet may be taken while the
// previous result still waits in the output register.
// If the receiver stalls, the result is held in the output register and a
// finished calculation waits for it to drain. Reset returns the flow to the
// idle state, clears all counters and loads the register defaults.
module openvpn_flow_classifier_fsm (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // opcode, src_addr_high, src_addr_low, dst_addr_high, dst_addr_low,
    // has_client_hello, rtp_header_ok, packet_len, flow_packets, zero fill
    input  logic [ovfc_pkg::IN_W-1:0]   s_axis_tdata,
    // addr_is_v6
    input  logic [0:0]                  s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // flow_state, confidence_valid, confidence, zero fill
    output logic [ovfc_pkg::OUT_W-1:0]  m_axis_tdata,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ovfc_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import ovfc_pkg::*;

    localparam logic [1:0] SEQ_IDLE = 2'd0;
    localparam logic [1:0] SEQ_PREP = 2'd1;
    localparam logic [1:0] SEQ_DIV  = 2'd2;
    localparam logic [1:0] SEQ_FIN  = 2'd3;

    logic [1:0]        r_seq;
    t_flow_state       r_state;
    logic [2:0]        r_miss;
    logic [63:0]       r_cli_hi;
    logic [63:0]       r_cli_lo;
    logic              r_cli_v6;
    t_count            r_data;
    t_count            r_large;
    logic [2:0]        r_thr;
    logic [15:0]       r_min_len;
    logic              r_total_gt;
    logic [NUM_W-1:0]  r_num;
    logic [NUM_W-1:0]  r_div;
    logic [6:0]        r_quot;
    logic [2:0]        r_bit;
    logic              r_res_cv;
    logic              r_out_valid;
    t_flow_state       r_out_state;
    logic              r_out_cv;
    logic [6:0]        r_out_conf;

    logic [4:0]        in_op;
    logic [63:0]       in_src_hi;
    logic [63:0]       in_src_lo;
    logic [63:0]       in_dst_hi;
    logic [63:0]       in_dst_lo;
    logic              in_v6;
    logic              in_hello;
    logic              in_rtp;
    logic [15:0]       in_len;
    logic [31:0]       in_total;

    logic              accept;
    logic              cfg_wr;
    logic              src_is_client;
    logic              dst_is_client;
    logic              is_large;
    logic              is_data_op;
    logic [2:0]        miss1;
    logic [2:0]        miss2;
    t_flow_state       n_state;
    logic [2:0]        n_miss;
    logic              load_client;
    logic [NUM_W-1:0]  num80;
    logic [RAT_W-1:0]  data5;
    logic [RAT_W-1:0]  large3;
    logic              ratio_ok;
    logic              div_ge;
    logic              out_free;

    assign in_op     = s_axis_tdata[4:0];
    assign in_src_hi = s_axis_tdata[68:5];
    assign in_src_lo = s_axis_tdata[132:69];
    assign in_dst_hi = s_axis_tdata[196:133];
    assign in_dst_lo = s_axis_tdata[260:197];
    assign in_hello  = s_axis_tdata[261];
    assign in_rtp    = s_axis_tdata[262];
    assign in_len    = s_axis_tdata[278:263];
    assign in_total  = s_axis_tdata[310:279];
    assign in_v6     = s_axis_tuser[0];

    assign s_axis_tready = (r_seq == SEQ_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign cfg_wr        = psel && penable && pwrite;
    assign pready        = 1'b1;
    assign out_free      = !r_out_valid || m_axis_tready;

    always_comb begin
        case (paddr[2])
            REG_MISS_THR: prdata = {29'd0, r_thr};
            default:      prdata = {16'd0, r_min_len};
        endcase
    end

    assign src_is_client = (in_v6 == r_cli_v6) && (in_src_hi == r_cli_hi)
                           && (in_src_lo == r_cli_lo);
    assign dst_is_client = (in_v6 == r_cli_v6) && (in_dst_hi == r_cli_hi)
                           && (in_dst_lo == r_cli_lo);
    assign is_large   = (in_len > r_min_len) && !in_rtp;
    assign is_data_op = (in_op == OP_DATA_V1) || (in_op == OP_DATA_V2);
    assign miss1      = (r_miss == MISS_MAX) ? MISS_MAX : r_miss + 3'd1;
    assign miss2      = (miss1 == MISS_MAX) ? MISS_MAX : miss1 + 3'd1;

    always_comb begin
        n_state     = r_state;
        n_miss      = miss1;
        load_client = 1'b0;
        case (in_op)
            OP_HRC_V1, OP_HRC_V2, OP_HRC_V3: begin
                n_state     = ST_RESET_CLIENT;
                n_miss      = 3'd0;
                load_client = 1'b1;
            end
            OP_HRS_V1, OP_HRS_V2: begin
                if (r_state == ST_RESET_CLIENT && dst_is_client) begin
                    n_state = ST_RESET_SERVER;
                    n_miss  = 3'd0;
                end else begin
                    n_miss = miss2;
                    if (r_thr != 3'd0 && miss2 == r_thr) begin
                        n_state = ST_INVALID;
                    end
                end
            end
            OP_CONTROL: begin
                if (r_state == ST_ACK && src_is_client && in_hello) begin
                    n_state = ST_CLIENT_HELLO;
                    n_miss  = 3'd0;
                end else if (r_state == ST_CLIENT_HELLO && dst_is_client && in_hello) begin
                    n_state = ST_SERVER_HELLO;
                    n_miss  = 3'd0;
                end else if (r_state == ST_SERVER_HELLO || r_state == ST_CONTROL_ACK) begin
                    n_state = ST_CONTROL_ACK;
                    n_miss  = 3'd0;
                end else begin
                    n_miss = miss2;
                    if (r_thr != 3'd0 && miss2 == r_thr) begin
                        n_state = ST_INVALID;
                    end
                end
            end
            OP_ACK: begin
                if (r_state == ST_RESET_SERVER && src_is_client) begin
                    n_state = ST_ACK;
                    n_miss  = 3'd0;
                end else if (r_state == ST_SERVER_HELLO || r_state == ST_CONTROL_ACK) begin
                    n_state = ST_CONTROL_ACK;
                    n_miss  = 3'd0;
                end
            end
            OP_DATA_V1, OP_DATA_V2: begin
                if (r_state == ST_CONTROL_ACK || r_state == ST_DATA) begin
                    n_state = ST_DATA;
                    n_miss  = 3'd0;
                end
            end
            default: begin
            end
        endcase
        if (n_miss >= MISS_LIMIT) begin
            n_state = ST_INVALID;
            n_miss  = 3'd0;
        end
    end

    assign num80    = ({7'd0, r_data} << 6) + ({7'd0, r_data} << 4);
    assign data5    = ({3'd0, r_data} << 2) + {3'd0, r_data};
    assign large3   = ({3'd0, r_large} << 1) + {3'd0, r_large};
    assign ratio_ok = (r_large > CNT_W'(MIN_PKTS)) && (r_data <= r_large)
                      && (data5 >= large3);
    assign div_ge   = (r_num >= r_div);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq       <= SEQ_IDLE;
            r_state     <= ST_IDLE;
            r_miss      <= 3'd0;
            r_cli_hi    <= 64'd0;
            r_cli_lo    <= 64'd0;
            r_cli_v6    <= 1'b0;
            r_data      <= '0;
            r_large     <= '0;
            r_thr       <= 3'd4;
            r_min_len   <= 16'd100;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_wr) begin
                case (paddr[2])
                    REG_MISS_THR: r_thr     <= pwdata[2:0];
                    default:      r_min_len <= pwdata[15:0];
                endcase
            end
            if (r_seq == SEQ_FIN && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_seq)
                SEQ_IDLE: begin
                    if (accept) begin
                        r_state    <= n_state;
                        r_miss     <= n_miss;
                        r_total_gt <= (in_total > MIN_PKTS);
                        if (load_client) begin
                            r_cli_hi <= in_src_hi;
                            r_cli_lo <= in_src_lo;
                            r_cli_v6 <= in_v6;
                        end
                        if (is_large) begin
                            r_large <= (r_large == '1) ? r_large : r_large + 1'b1;
                            if (is_data_op) begin
                                r_data <= (r_data == '1) ? r_data : r_data + 1'b1;
                            end
                        end
                        r_seq <= SEQ_PREP;
                    end
                end
                SEQ_PREP: begin
                    r_num  <= num80;
                    r_div  <= {7'd0, r_large} << 6;
                    r_bit  <= 3'd6;
                    if (r_total_gt && r_state == ST_DATA) begin
                        r_res_cv <= 1'b1;
                        r_quot   <= CONF_FULL;
                        r_seq    <= SEQ_FIN;
                    end else if (ratio_ok) begin
                        r_res_cv <= 1'b1;
                        r_quot   <= 7'd0;
                        r_seq    <= SEQ_DIV;
                    end else begin
                        r_res_cv <= 1'b0;
                        r_quot   <= 7'd0;
                        r_seq    <= SEQ_FIN;
                    end
                end
                SEQ_DIV: begin
                    if (div_ge) begin
                        r_num <= r_num - r_div;
                    end
                    r_div  <= r_div >> 1;
                    r_quot <= {r_quot[5:0], div_ge};
                    r_bit  <= r_bit - 3'd1;
                    if (r_bit == 3'd0) begin
                        r_seq <= SEQ_FIN;
                    end
                end
                default: begin
                    if (out_free) begin
                        r_out_state <= r_state;
                        r_out_cv    <= r_res_cv;
                        r_out_conf  <= r_quot;
                        r_seq       <= SEQ_IDLE;
                    end
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'd0, r_out_conf, r_out_cv, r_out_state};

endmodule

[rtl/core/ovfc_checker.sv]
`include "openvpn_flow_classifier_fsm_macros.svh"

module ovfc_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       m_axis_tvalid,
    input logic                       m_axis_tready,
    input logic [ovfc_pkg::OUT_W-1:0] m_axis_tdata,
    input logic                       pready
);
    import ovfc_pkg::*;

    `OVFC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    `OVFC_ASSERT_SAME(a_conf_zero, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tdata[4], m_axis_tdata[11:5] == 7'd0)
    `OVFC_ASSERT_SAME(a_conf_range, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[11:5] <= CONF_MAX)
    `OVFC_ASSERT_SAME(a_state_range, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[3:0] <= STATE_MAX)
    `OVFC_ASSERT_SAME(a_pready, i_clk, i_rst_n, 1'b1, pready)

endmodule

bind openvpn_flow_classifier_fsm ovfc_checker u_ovfc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .pready        (pready)
);
